// ===== rtl/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation unit.
package mexp_pkg;

  localparam int WIDTH      = 16;
  localparam int CNT_W      = (WIDTH > 2) ? $clog2(WIDTH) : 1;
  localparam int DATA_W     = ((WIDTH + 7) / 8) * 8;
  localparam int CFG_ADDR_W = 1;

  // register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_EXPONENT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_OUT
  } state_t;

  // request to the shared modular multiplier
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] x;
    logic [WIDTH-1:0] y;
  } mul_ctrl_t;

  // multiplier status back to the sequencer
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WIDTH-1:0] result;
  } mul_stat_t;

endpackage

// ===== rtl/mexp_mulmod.sv =====
// Bit-serial modular multiplier: (x * y) mod m, one bit of y per cycle.
module mexp_mulmod (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [mexp_pkg::WIDTH-1:0] modulus,
  input  mexp_pkg::mul_ctrl_t      ctl,
  output mexp_pkg::mul_stat_t      stat
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] x_r, x_nxt;
  logic [WIDTH-1:0] y_r, y_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] step;

  // (a + b) mod m for a, b < m
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] gap;
    gap = m - b;
    if (a >= gap) return a - gap;
    return a + b;
  endfunction

  always_comb begin
    dbl  = add_mod(acc_r, acc_r, modulus);
    step = y_r[WIDTH-1] ? add_mod(dbl, x_r, modulus) : dbl;
  end

  always_comb begin
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start && !busy_r) begin
      acc_nxt  = '0;
      x_nxt    = ctl.x;
      y_nxt    = ctl.y;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = step;
      y_nxt   = {y_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign stat.busy   = busy_r;
  assign stat.done   = done_r;
  assign stat.result = acc_r;

  // sequencer never issues a new operation while one is running
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("multiplier started while busy");

  // a finished product is always reduced
  a_done_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < modulus))
    else $error("multiplier result not below modulus");

  // done is flagged only once the unit has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("multiplier done while still busy");

endmodule

// ===== rtl/modular_exponentiation_unit.sv =====
// Top level: modular exponentiation by right-to-left square and multiply.
//
// Each input transaction carries a base; the block returns
// base^exponent mod modulus as one output transaction. modulus and exponent
// are config registers (reset 143 and 23) written through cfg_we/cfg_addr/
// cfg_wdata; the user must write them only while the block is idle, which the
// block itself does not enforce. Exponent zero gives 1 (also for modulus 1);
// modulus zero gives 0. One transaction at a time: in_tready is high only
// when the sequencer is idle. All arithmetic runs on a single bit-serial
// modular multiplier. The base is first reduced on that unit, then for each
// of the WIDTH exponent bits the sequencer passes a step state, a multiply
// when the bit is set and a squaring except after the top bit. The result
// sits in an output register, so the next base is taken while a result
// still waits.
module modular_exponentiation_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // config write port
  input  logic                             cfg_we,
  input  logic [mexp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mexp_pkg::WIDTH-1:0]       cfg_wdata,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mexp_pkg::DATA_W-1:0]      in_tdata,   // [WIDTH-1:0] base, rest zero
  // output stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mexp_pkg::DATA_W-1:0]      out_tdata   // [WIDTH-1:0] power, rest zero
);
  import mexp_pkg::*;

  // config registers
  logic [WIDTH-1:0] modulus_r;
  logic [WIDTH-1:0] exponent_r;

  // sequencer
  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;    // running result
  logic [WIDTH-1:0] sq_r, sq_nxt;      // running square
  logic [CNT_W-1:0] bit_r, bit_nxt;    // exponent bit position
  mul_ctrl_t        ctl_r, ctl_nxt;
  mul_stat_t        stat;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt;

  logic             in_acc;
  logic             last_bit;
  logic [WIDTH-1:0] one_val;           // 1 mod modulus

  assign in_acc   = in_tvalid && in_tready;
  assign last_bit = (bit_r == CNT_W'(WIDTH - 1));
  assign one_val  = (modulus_r == WIDTH'(1)) ? '0 : WIDTH'(1);

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (modulus_r),
    .ctl     (ctl_r),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= WIDTH'(143);
      exponent_r <= WIDTH'(23);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODULUS:  modulus_r  <= cfg_wdata;
        REG_EXPONENT: exponent_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    bit_nxt       = bit_r;
    ctl_nxt       = ctl_r;
    ctl_nxt.start = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          bit_nxt = '0;
          if (modulus_r == '0) begin
            acc_nxt   = '0;
            state_nxt = ST_OUT;
          end else if (exponent_r == '0) begin
            acc_nxt   = WIDTH'(1);
            state_nxt = ST_OUT;
          end else begin
            // base mod m = (1 mod m) * base mod m
            acc_nxt       = one_val;
            ctl_nxt.start = 1'b1;
            ctl_nxt.x     = one_val;
            ctl_nxt.y     = in_tdata[WIDTH-1:0];
            state_nxt     = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (stat.done) begin
          sq_nxt    = stat.result;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (exponent_r[bit_r]) begin
          ctl_nxt.start = 1'b1;
          ctl_nxt.x     = acc_r;
          ctl_nxt.y     = sq_r;
          state_nxt     = ST_MUL;
        end else if (last_bit) begin
          state_nxt = ST_OUT;
        end else begin
          ctl_nxt.start = 1'b1;
          ctl_nxt.x     = sq_r;
          ctl_nxt.y     = sq_r;
          state_nxt     = ST_SQR;
        end
      end
      ST_MUL: begin
        if (stat.done) begin
          acc_nxt = stat.result;
          if (last_bit) begin
            state_nxt = ST_OUT;
          end else begin
            ctl_nxt.start = 1'b1;
            ctl_nxt.x     = sq_r;
            ctl_nxt.y     = sq_r;
            state_nxt     = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (stat.done) begin
          sq_nxt    = stat.result;
          bit_nxt   = bit_r + 1'b1;
          state_nxt = ST_STEP;
        end
      end
      ST_OUT: begin
        // hand over once the output register is free or being emptied
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ctl_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ctl_r       <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);

  // multiplier results only arrive while an operation is outstanding
  a_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (state_r == ST_RED || state_r == ST_MUL || state_r == ST_SQR))
    else $error("multiplier done outside an operation");

  // zero modulus bypasses the multiplier entirely
  a_mod_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && modulus_r == '0) |=> (state_r == ST_OUT && acc_r == '0))
    else $error("zero modulus not short-cut");

  // a result is never dropped: a stalled output is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result overwritten");

endmodule

// ===== tb/tb.sv =====
// Testbench for the modular exponentiation unit: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module tb;
  import mexp_pkg::*;

  typedef logic [WIDTH-1:0] word_t;

  // One directed row: register setting, base, and the power when it is
  // obvious from the math (known=1); otherwise the predictor supplies it.
  typedef struct packed {
    word_t modulus;
    word_t exponent;
    word_t base;
    logic  known;
    word_t power;
  } base_case_t;

  localparam int    IDLE_PCT        = 30;    // percent chance of idling, each side
  localparam int    MAX_GAP         = 300;   // longest sender gap, cycles
  localparam int    STALL_CYCLES    = 1500;  // one long receiver hold-off
  localparam int    QUIET_LIMIT     = 8000;  // cycles with no transaction -> hang
  localparam int    SETTLE_CYCLES   = 20;    // quiet time after the last result
  localparam int    PHASES          = 22;
  localparam int    BASES_PER_PHASE = 50;
  localparam int    NO_IDLE_PHASE   = 3;     // both sides run flat out
  localparam int    HOLD_PHASE      = 5;     // receiver hold-off happens here
  localparam int    MAX_SHOWN       = 10;
  localparam word_t MOD_RESET       = 16'd143;
  localparam word_t EXP_RESET       = 16'd23;
  localparam word_t TOP_BIT         = word_t'(1) << (WIDTH - 1);

  // corner values for modulus and exponent draws
  localparam word_t CORNER_VALS [5] = '{16'd0, 16'd1, 16'd2, 16'hFFFF, TOP_BIT};

  // Directed table. Covers: reset setting, zero/all-ones bases, base equal to
  // the modulus, exponent zero (also with base zero), modulus one with and
  // without exponent, modulus zero, full-range modulus and exponent, a prime
  // modulus, a power-of-two modulus and alternating bit patterns.
  localparam int N_CASES = 20;
  localparam base_case_t BASE_CASES [N_CASES] = '{
    '{16'd143,   16'd23,    16'h0000, 1'b1, 16'd0},
    '{16'd143,   16'd23,    16'h0001, 1'b1, 16'd1},
    '{16'd143,   16'd23,    16'h0002, 1'b0, 16'd0},
    '{16'd143,   16'd23,    16'hFFFF, 1'b0, 16'd0},
    '{16'd143,   16'd23,    16'd143,  1'b1, 16'd0},
    '{16'd143,   16'd0,     16'h0000, 1'b1, 16'd1},
    '{16'd143,   16'd0,     16'hFFFF, 1'b1, 16'd1},
    '{16'd1,     16'd0,     16'h1234, 1'b1, 16'd1},
    '{16'd1,     16'hFFFF,  16'hFFFF, 1'b1, 16'd0},
    '{16'd0,     16'd23,    16'h0007, 1'b1, 16'd0},
    '{16'd0,     16'd0,     16'hFFFF, 1'b1, 16'd0},
    '{16'hFFFF,  16'hFFFF,  16'hFFFE, 1'b0, 16'd0},
    '{16'hFFFF,  16'd1,     16'hFFFF, 1'b1, 16'd0},
    '{16'hFFFF,  16'd1,     16'h1234, 1'b1, 16'h1234},
    '{16'd2,     16'd1,     16'hFFFF, 1'b1, 16'd1},
    '{16'd65521, 16'd65520, 16'd12345, 1'b0, 16'd0},
    '{16'h8000,  16'h8000,  16'h0003, 1'b0, 16'd0},
    '{16'h8000,  16'h8000,  16'hAAAA, 1'b0, 16'd0},
    '{16'd143,   16'd7,     16'h5555, 1'b0, 16'd0},
    '{16'd143,   16'd7,     16'hAAAA, 1'b0, 16'd0}
  };

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_MODULUS;
  logic [WIDTH-1:0]  cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;

  // predictor's copy of the two registers
  word_t cur_mod = MOD_RESET;
  word_t cur_exp = EXP_RESET;

  word_t power_q [$];      // expected powers, oldest first
  int    errors      = 0;
  int    sent        = 0;
  int    checked     = 0;
  int    settings    = 0;
  int    quiet       = 0;
  bit    tx_gaps     = 1'b1;
  logic  rx_idle     = 1'b1;
  logic  hold_go     = 1'b0;

  modular_exponentiation_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] base
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // [15:0] power
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Right-to-left square and multiply; double-width products, so a plain
  // remainder matches the block's bit-serial reduction.
  function automatic word_t expected_power(word_t b, word_t e, word_t m);
    logic [2*WIDTH-1:0] acc;
    logic [2*WIDTH-1:0] sq;
    if (m == '0) return '0;
    if (e == '0) return word_t'(1);
    acc = 1 % m;
    sq  = b % m;
    for (int i = 0; i < WIDTH; i++) begin
      if (e[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return word_t'(acc);
  endfunction

  // Random register value: corners, a small range, or anything.
  function automatic word_t random_setting(int small_hi);
    int k;
    k = $urandom_range(9);
    if (k == 0) return CORNER_VALS[$urandom_range(4)];
    if (k <= 3) return word_t'($urandom_range(small_hi));
    return word_t'($urandom);
  endfunction

  // Offer one base; the expectation is queued at the accepting edge.
  task automatic send_base(input word_t b, input logic known, input word_t pow);
    if (tx_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'(b);
    do @(posedge clk); while (!in_tready);
    power_q.insert(power_q.size(),
                   known ? pow : expected_power(b, cur_exp, cur_mod));
    sent++;
  endtask

  // Sender pauses until every queued power has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (power_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; only called with the block idle.
  task automatic load_config(input word_t m, input word_t e);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_MODULUS;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_addr  <= REG_EXPONENT;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    cur_mod = m;
    cur_exp = e;
    settings++;
  endtask

  // Result checker: every output transaction against the oldest expectation.
  always @(posedge clk) begin
    word_t want;
    if (out_tvalid && out_tready) begin
      checked++;
      if (power_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("ERROR: unexpected result power=%h", out_tdata[WIDTH-1:0]);
      end else begin
        want = power_q.pop_front();
        if (out_tdata[WIDTH-1:0] !== want) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("ERROR: power mismatch: expected %h, got %h",
                     want, out_tdata[WIDTH-1:0]);
        end
      end
    end
  end

  // Hang detector: any transaction on either stream resets the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles, %0d results pending",
               quiet, power_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Receiver: random backpressure, or none, plus one long hold-off that it
  // counts itself once hold_go rises. The hold-off fills the output register
  // and the sequencer, so in_tready has to drop while bases keep coming.
  initial begin
    int held;
    bit hold_done;
    held      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_tready <= 1'b0;
        held++;
        if (held >= STALL_CYCLES) hold_done = 1'b1;
      end else if (rx_idle) begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed table, random phases, verdict.
  initial begin
    word_t m;
    word_t e;
    word_t b;
    int    k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; a new register setting waits for the block to go idle
    for (int i = 0; i < N_CASES; i++) begin
      if (BASE_CASES[i].modulus != cur_mod || BASE_CASES[i].exponent != cur_exp) begin
        drain();
        load_config(BASE_CASES[i].modulus, BASE_CASES[i].exponent);
      end
      send_base(BASE_CASES[i].base, BASE_CASES[i].known, BASE_CASES[i].power);
    end
    drain();

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p == HOLD_PHASE) begin
        // short exponent so the block turns bases around fast and backs up
        m = 16'd1009;
        e = 16'd5;
      end else begin
        m = random_setting(255);
        e = random_setting(31);
      end
      load_config(m, e);
      tx_gaps = (p != NO_IDLE_PHASE);
      rx_idle <= (p != NO_IDLE_PHASE);
      for (int n = 0; n < BASES_PER_PHASE; n++) begin
        if (p == HOLD_PHASE && n == 5) hold_go <= 1'b1;
        // lean on bases that reduce to 0, to modulus-1, and the extremes
        k = $urandom_range(9);
        case (k)
          0:       b = '0;
          1:       b = '1;
          2:       b = cur_mod - 1'b1;
          3:       b = cur_mod;
          default: b = word_t'($urandom);
        endcase
        send_base(b, 1'b0, '0);
      end
      drain();
    end

    $display("Summary: %0d bases over %0d register settings, %0d results checked,",
             sent, settings, checked);
    $display("  incl. modulus 0/1/max, exponent 0/max and a %0d-cycle receiver hold-off",
             STALL_CYCLES);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation_unit.sv
tb/tb.sv
